// File: src/c2d_pkg.sv
// ----------------------------------------------------------------------------
// c2d_pkg: shared types and constants of the convolution layer engine
// Store geometry, command codes, register indexes and the queued command.
// ----------------------------------------------------------------------------
package c2d_pkg;

   localparam int MAX_IN_DEPTH     = 8;
   localparam int MAX_IN_SIZE      = 32;
   localparam int MAX_OUT_DEPTH    = 8;
   localparam int KERNEL_HEIGHT    = 3;
   localparam int KERNEL_WIDTH     = 3;
   localparam int WEIGHT_FRAC_BITS = 12;

   localparam int MAP_WORDS = MAX_IN_DEPTH * MAX_IN_SIZE * MAX_IN_SIZE;
   localparam int WT_WORDS  = MAX_OUT_DEPTH * MAX_IN_DEPTH * KERNEL_HEIGHT * KERNEL_WIDTH;
   localparam int MAP_AW    = $clog2(MAP_WORDS);
   localparam int WT_AW     = $clog2(WT_WORDS);

   localparam logic [1:0] CMD_LOAD_INPUT  = 2'd0;
   localparam logic [1:0] CMD_LOAD_WEIGHT = 2'd1;
   localparam logic [1:0] CMD_LOAD_BIAS   = 2'd2;
   localparam logic [1:0] CMD_COMPUTE     = 2'd3;

   localparam logic [2:0] REG_STRIDE       = 3'd0;
   localparam logic [2:0] REG_PADDING      = 3'd1;
   localparam logic [2:0] REG_USE_BIAS     = 3'd2;
   localparam logic [2:0] REG_USE_RESIDUAL = 3'd3;
   localparam logic [2:0] REG_IN_DEPTH     = 3'd4;
   localparam logic [2:0] REG_IN_HEIGHT    = 3'd5;
   localparam logic [2:0] REG_IN_WIDTH     = 3'd6;

   typedef struct packed {
      logic [1:0]         command;
      logic [2:0]         in_channel;
      logic [2:0]         out_channel;
      logic [5:0]         row;
      logic [5:0]         col;
      logic [1:0]         kernel_row;
      logic [1:0]         kernel_col;
      logic signed [15:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]         result_channel;
      logic [5:0]         result_row;
      logic [5:0]         result_col;
      logic signed [15:0] result_value;
   } rsp_type;

   typedef struct packed {
      logic [2:0] stride;
      logic [1:0] padding;
      logic       use_bias;
      logic       use_residual;
      logic [3:0] in_depth;
      logic [5:0] in_height;
      logic [5:0] in_width;
   } cfg_type;

endpackage

// File: src/c2d_req_if.sv
// ----------------------------------------------------------------------------
// c2d_req_if: request channel
// Valid/ready channel that carries one command.
// ----------------------------------------------------------------------------
interface c2d_req_if;
   logic              valid;
   logic              ready;
   c2d_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: src/c2d_rsp_if.sv
// ----------------------------------------------------------------------------
// c2d_rsp_if: result channel
// Valid/ready channel that carries one computed output point.
// ----------------------------------------------------------------------------
interface c2d_rsp_if;
   logic              valid;
   logic              ready;
   c2d_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: src/conv2d_layer_engine.sv
// ----------------------------------------------------------------------------
// conv2d_layer_engine: 2D convolution layer with bias and residual
// Top level: configuration registers, command queue and compute sequencer.
// ----------------------------------------------------------------------------
// Load commands are written into the stores when taken in the idle state. For a
// compute command every kernel tap goes through address, memory read and multiply,
// then accumulate, on one shared multiplier. A two-entry queue lets commands arrive
// while a compute runs.
module conv2d_layer_engine (
   input  logic        clock,
   input  logic        reset,
   c2d_req_if.sink     req,
   c2d_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [5:0]  csr_wdata
);
   c2d_pkg::cfg_type cfg_ff, cfg_in;
   c2d_pkg::req_type cmd_data;
   logic cmd_valid, cmd_take;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            c2d_pkg::REG_STRIDE:       cfg_in.stride = csr_wdata[2:0];
            c2d_pkg::REG_PADDING:      cfg_in.padding = csr_wdata[1:0];
            c2d_pkg::REG_USE_BIAS:     cfg_in.use_bias = csr_wdata[0];
            c2d_pkg::REG_USE_RESIDUAL: cfg_in.use_residual = csr_wdata[0];
            c2d_pkg::REG_IN_DEPTH:     cfg_in.in_depth = csr_wdata[3:0];
            c2d_pkg::REG_IN_HEIGHT:    cfg_in.in_height = csr_wdata;
            c2d_pkg::REG_IN_WIDTH:     cfg_in.in_width = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{stride: 3'd1, padding: 2'd0, use_bias: 1'b0, use_residual: 1'b0,
                    in_depth: 4'd8, in_height: 6'd32, in_width: 6'd32};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   c2d_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .cmd_data(cmd_data), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
   );

   c2d_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .cmd_data(cmd_data), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .rsp(rsp)
   );
endmodule

// File: src/c2d_front.sv
// ----------------------------------------------------------------------------
// c2d_front: command intake
// Two-entry queue that takes commands and hands them to the compute side.
// ----------------------------------------------------------------------------
module c2d_front (
   input  logic              clock,
   input  logic              reset,
   c2d_req_if.sink           req,
   output c2d_pkg::req_type  cmd_data,
   output logic              cmd_valid,
   input  logic              cmd_take
);
   c2d_pkg::req_type q_ff [2];
   c2d_pkg::req_type q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign req.ready = (cnt_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop       = cmd_valid && cmd_take;
   assign cmd_data  = q_ff[0];

   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      cnt_in  = cnt_ff + 2'(push) - 2'(pop);
      if (pop) begin
         q_in[0] = q_ff[1];
      end
      if (push) begin
         if (cnt_ff - 2'(pop) == 2'd0) begin
            q_in[0] = req.payload;
         end else begin
            q_in[1] = req.payload;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count out of range");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !req.ready) else $error("full queue accepted");
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> cnt_ff == $past(cnt_ff) - 2'd1) else $error("pop lost");
endmodule

// File: src/c2d_back.sv
// ----------------------------------------------------------------------------
// c2d_back: store and multiply-accumulate sequencer
// Writes loads into the stores and walks the taps of a compute command.
// ----------------------------------------------------------------------------
module c2d_back (
   input  logic              clock,
   input  logic              reset,
   input  c2d_pkg::cfg_type  cfg,
   input  c2d_pkg::req_type  cmd_data,
   input  logic              cmd_valid,
   output logic              cmd_take,
   c2d_rsp_if.source         rsp
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_TAP  = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_ACC  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   localparam logic [1:0] A_LAST = 2'(c2d_pkg::KERNEL_HEIGHT - 1);
   localparam logic [1:0] B_LAST = 2'(c2d_pkg::KERNEL_WIDTH - 1);

   logic [15:0] map_mem [c2d_pkg::MAP_WORDS];
   logic [15:0] wt_mem  [c2d_pkg::WT_WORDS];
   logic [15:0] bias_mem [c2d_pkg::MAX_OUT_DEPTH];

   logic [2:0] st_ff, st_in;
   c2d_pkg::req_type cur_ff, cur_in;
   logic [3:0] d_ff, d_in;
   logic [1:0] a_ff, a_in, b_ff, b_in;
   logic [15:0] acc_ff, acc_in;
   logic        hit_ff, hit_in;
   logic [15:0] map_rd_ff, wt_rd_ff;
   logic signed [31:0] prod_ff, prod_in;
   c2d_pkg::rsp_type rsp_ff, rsp_in;
   logic        rv_ff, rv_in;

   logic [3:0] depth_c;
   logic [5:0] h_c, w_c;
   logic signed [9:0] ti, tj;
   logic [c2d_pkg::MAP_AW-1:0] map_wa, map_ra;
   logic [c2d_pkg::WT_AW-1:0]  wt_wa, wt_ra;
   logic map_we, wt_we, bias_we;
   logic signed [15:0] bias_s;
   logic last_tap;

   assign depth_c = (cfg.in_depth > 4'(c2d_pkg::MAX_IN_DEPTH)) ?
                    4'(c2d_pkg::MAX_IN_DEPTH) : cfg.in_depth;
   assign h_c = (cfg.in_height > 6'(c2d_pkg::MAX_IN_SIZE)) ?
                6'(c2d_pkg::MAX_IN_SIZE) : cfg.in_height;
   assign w_c = (cfg.in_width > 6'(c2d_pkg::MAX_IN_SIZE)) ?
                6'(c2d_pkg::MAX_IN_SIZE) : cfg.in_width;

   assign ti = 10'(cfg.stride * cur_ff.row) - 10'(cfg.padding) + 10'(a_ff);
   assign tj = 10'(cfg.stride * cur_ff.col) - 10'(cfg.padding) + 10'(b_ff);
   // The address is only meaningful for taps inside the map; others are dropped.
   assign map_ra = c2d_pkg::MAP_AW'((d_ff * c2d_pkg::MAX_IN_SIZE + ti)
                   * c2d_pkg::MAX_IN_SIZE + tj);
   assign wt_ra = c2d_pkg::WT_AW'(((cur_ff.out_channel * c2d_pkg::MAX_IN_DEPTH + d_ff)
                  * c2d_pkg::KERNEL_HEIGHT + a_ff) * c2d_pkg::KERNEL_WIDTH + b_ff);
   assign last_tap = (b_ff == B_LAST) && (a_ff == A_LAST) && (d_ff + 4'd1 >= depth_c);

   assign map_we  = st_ff == ST_IDLE && cmd_valid && cmd_data.command == c2d_pkg::CMD_LOAD_INPUT
                    && cmd_data.row < 6'(c2d_pkg::MAX_IN_SIZE)
                    && cmd_data.col < 6'(c2d_pkg::MAX_IN_SIZE);
   assign wt_we   = st_ff == ST_IDLE && cmd_valid && cmd_data.command == c2d_pkg::CMD_LOAD_WEIGHT
                    && cmd_data.kernel_row < 2'(c2d_pkg::KERNEL_HEIGHT)
                    && cmd_data.kernel_col < 2'(c2d_pkg::KERNEL_WIDTH);
   assign bias_we = st_ff == ST_IDLE && cmd_valid && cmd_data.command == c2d_pkg::CMD_LOAD_BIAS;
   assign map_wa  = c2d_pkg::MAP_AW'((cmd_data.in_channel * c2d_pkg::MAX_IN_SIZE
                    + cmd_data.row) * c2d_pkg::MAX_IN_SIZE + cmd_data.col);
   assign wt_wa   = c2d_pkg::WT_AW'(((cmd_data.out_channel * c2d_pkg::MAX_IN_DEPTH
                    + cmd_data.in_channel) * c2d_pkg::KERNEL_HEIGHT + cmd_data.kernel_row)
                    * c2d_pkg::KERNEL_WIDTH + cmd_data.kernel_col);
   assign bias_s  = bias_mem[cmd_data.out_channel];

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_wa] <= cmd_data.value;
      end
      if (wt_we) begin
         wt_mem[wt_wa] <= cmd_data.value;
      end
      if (bias_we) begin
         bias_mem[cmd_data.out_channel] <= cmd_data.value;
      end
      map_rd_ff <= map_mem[map_ra];
      wt_rd_ff  <= wt_mem[wt_ra];
   end

   assign cmd_take = (st_ff == ST_IDLE) && cmd_valid &&
                     (cmd_data.command != c2d_pkg::CMD_COMPUTE || !rv_ff);
   assign rsp.valid = rv_ff;
   assign rsp.payload = rsp_ff;

   always_comb begin
      st_in = st_ff; cur_in = cur_ff; d_in = d_ff; a_in = a_ff; b_in = b_ff;
      acc_in = acc_ff; hit_in = hit_ff; prod_in = prod_ff;
      rsp_in = rsp_ff; rv_in = rv_ff && !rsp.ready;
      unique case (st_ff)
         ST_IDLE: begin
            if (cmd_take && cmd_data.command == c2d_pkg::CMD_COMPUTE) begin
               cur_in = cmd_data;
               d_in = 4'd0; a_in = 2'd0; b_in = 2'd0;
               // Bias is Q4.12; flooring to Q8.8 is an arithmetic shift.
               acc_in = cfg.use_bias ? 16'(bias_s >>> (c2d_pkg::WEIGHT_FRAC_BITS - 8)) : 16'd0;
               if (cfg.use_residual) begin
                  acc_in = acc_in + cmd_data.value;
               end
               st_in = (depth_c == 4'd0) ? ST_OUT : ST_TAP;
            end
         end
         ST_TAP: begin
            hit_in = !ti[9] && !tj[9] && (ti < 10'(h_c)) && (tj < 10'(w_c));
            st_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in = $signed(map_rd_ff) * $signed(wt_rd_ff);
            st_in = ST_ACC;
         end
         ST_ACC: begin
            if (hit_ff) begin
               acc_in = acc_ff + prod_ff[c2d_pkg::WEIGHT_FRAC_BITS +: 16];
            end
            if (last_tap) begin
               st_in = ST_OUT;
            end else begin
               st_in = ST_TAP;
               if (b_ff == B_LAST) begin
                  b_in = 2'd0;
                  if (a_ff == A_LAST) begin
                     a_in = 2'd0; d_in = d_ff + 4'd1;
                  end else begin
                     a_in = a_ff + 2'd1;
                  end
               end else begin
                  b_in = b_ff + 2'd1;
               end
            end
         end
         ST_OUT: begin
            if (!rv_ff) begin
               rsp_in = '{result_channel: cur_ff.out_channel, result_row: cur_ff.row,
                          result_col: cur_ff.col, result_value: acc_ff};
               rv_in = 1'b1;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in; d_ff <= d_in; a_ff <= a_in; b_ff <= b_in;
      acc_ff <= acc_in; hit_ff <= hit_in; prod_ff <= prod_in; rsp_ff <= rsp_in;
      if (reset) begin
         st_ff <= ST_IDLE;
         rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         rv_ff <= rv_in;
      end
   end

   a_out_empty: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_OUT && !rv_ff |=> rv_ff) else $error("result not posted");
   a_tap_order: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_TAP |=> st_ff == ST_MUL) else $error("tap sequence broken");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      st_ff != ST_IDLE |-> !cmd_take) else $error("command taken while busy");
endmodule
